// ===== src/gcvbp_pkg.sv =====
package gcvbp_pkg;

  localparam int BLK_W      = 10;
  localparam int ENTRY_W    = 32;
  localparam int ERA_W      = 16;
  localparam int SCORE_W    = 32;
  localparam int WEIGHT_W   = 8;
  localparam int CODE_W     = 16;
  localparam int PPB_W      = 11;
  localparam int COUNT_W    = 11;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam int NUM_BLOCKS_DEF = 1024;
  localparam int FLAG_BITS_DEF  = 2;
  localparam int ID_BITS_DEF    = 16;

  localparam logic [COUNT_W-1:0]        COUNT_MAX   = '1;
  localparam int                        SCALE_SHIFT = 8;
  localparam logic signed [SCORE_W-1:0] SCORE_FLOOR = -32'sd2147483647;
  localparam logic [PPB_W-1:0]          PPB_RESET   = PPB_W'(64);

  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_ERASE_AGE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_DELETED   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_FREE      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_USED      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ERASE_COUNT  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PAGES_PER_BLOCK  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DELETED_ID_CODE  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_FREE_ID_CODE     = 3'd7;

  // Remainder of a block index by a constant block count, one restoring step per bit.
  function automatic logic [BLK_W-1:0] blk_mod(logic [BLK_W-1:0] v, int unsigned nb);
    logic [16:0] r;
    r = '0;
    for (int i = BLK_W - 1; i >= 0; i--) begin
      r = {r[15:0], v[i]};
      if (r >= 17'(nb)) begin
        r = r - 17'(nb);
      end
    end
    return r[BLK_W-1:0];
  endfunction

endpackage

// ===== src/gcvbp_if.sv =====
interface gcvbp_scan_if;
  logic                             valid;
  logic                             ready;
  logic [gcvbp_pkg::BLK_W-1:0]      block_index;
  logic [gcvbp_pkg::ENTRY_W-1:0]    lookup_entry;
  logic [gcvbp_pkg::ERA_W-1:0]      erase_count;
  logic                             last_entry;

  modport source (output valid, block_index, lookup_entry, erase_count, last_entry,
                  input ready);
  modport sink (input valid, block_index, lookup_entry, erase_count, last_entry,
                output ready);
endinterface

interface gcvbp_result_if;
  logic                                 valid;
  logic                                 ready;
  logic [gcvbp_pkg::BLK_W-1:0]          candidate_block;
  logic signed [gcvbp_pkg::SCORE_W-1:0] candidate_score;
  logic                                 found;

  modport source (output valid, candidate_block, candidate_score, found, input ready);
  modport sink (input valid, candidate_block, candidate_score, found, output ready);
endinterface

// ===== src/gc_victim_block_picker_core.sv =====
// Garbage-collection victim picker. The scan channel delivers one lookup entry
// per data page, tagged with its block index and erase count; the result
// channel returns one transaction for each entry marked last: the best block,
// its score and the found flag. Registers are written on the plain
// configuration port; the user must write them only while the block is idle,
// and the block itself does not enforce this. An entry that stays in the
// current block and is not last is absorbed without leaving the idle state.
// A change of block index scores the finished block first: the erase-age
// term, then for each of the three page fractions a multiply, a setup step,
// the bit-serial divider and an accumulate, then a compare. An entry marked
// last also scores its own block, and then the result moves into the output
// register and all scan state is cleared.
// The scan side is ready only between scoring passes.
// When the receiver stalls, the finished result waits in the output register;
// the next scan may proceed, and only its own final result waits for the
// register to free up.
// Synchronous reset restores the register defaults and clears the scan state.
module gc_victim_block_picker_core #(
  parameter int NUM_BLOCKS = gcvbp_pkg::NUM_BLOCKS_DEF,
  parameter int FLAG_BITS  = gcvbp_pkg::FLAG_BITS_DEF,
  parameter int ID_BITS    = gcvbp_pkg::ID_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wr_en,
  input  logic [gcvbp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [gcvbp_pkg::CFG_DATA_W-1:0]    cfg_data,
  gcvbp_scan_if.sink                          scan,
  gcvbp_result_if.source                      result
);

  localparam int EXT_W  = (FLAG_BITS + ID_BITS > gcvbp_pkg::ENTRY_W) ?
                          FLAG_BITS + ID_BITS : gcvbp_pkg::ENTRY_W;
  localparam int CW     = gcvbp_pkg::COUNT_W;
  localparam int WW     = gcvbp_pkg::WEIGHT_W;
  localparam int SW     = gcvbp_pkg::SCORE_W;
  localparam int PROD_W = WW + CW + 1;
  localparam int MAG_W  = WW + CW - 1;
  localparam int DIV_W  = MAG_W + gcvbp_pkg::SCALE_SHIFT;
  localparam int BIT_W  = $clog2(DIV_W);
  localparam int PW     = gcvbp_pkg::PPB_W;
  localparam int EAGE_W = WW + gcvbp_pkg::ERA_W + 1;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_EAGE = 4'd1;
  localparam logic [3:0] ST_MUL  = 4'd2;
  localparam logic [3:0] ST_PREP = 4'd3;
  localparam logic [3:0] ST_DIV  = 4'd4;
  localparam logic [3:0] ST_ACC  = 4'd5;
  localparam logic [3:0] ST_CMP  = 4'd6;
  localparam logic [3:0] ST_SNAP = 4'd7;
  localparam logic [3:0] ST_EMIT = 4'd8;

  logic [3:0] state;

  logic signed [WW-1:0]                 weight_erase_age, weight_deleted;
  logic signed [WW-1:0]                 weight_free, weight_used;
  logic [gcvbp_pkg::ERA_W-1:0]          max_erase_count;
  logic [PW-1:0]                        pages_per_block;
  logic [gcvbp_pkg::CODE_W-1:0]         deleted_id_code, free_id_code;

  logic                                 seen;
  logic [gcvbp_pkg::BLK_W-1:0]          cur_blk;
  logic [gcvbp_pkg::ERA_W-1:0]          cur_era;
  logic [CW-1:0]                        del_cnt, free_cnt, used_cnt;

  logic [gcvbp_pkg::BLK_W-1:0]          s_blk;
  logic [gcvbp_pkg::ERA_W-1:0]          s_era;
  logic [CW-1:0]                        s_del, s_free, s_used;

  logic signed [SW-1:0]                 best_score;
  logic [CW-1:0]                        best_del;
  logic [gcvbp_pkg::BLK_W-1:0]          best_blk;
  logic                                 best_valid;

  logic                                 pend_last, final_pass;
  logic [1:0]                           term;
  logic signed [PROD_W-1:0]             prod;
  logic                                 neg;
  logic [DIV_W-1:0]                     quo;
  logic [PW-1:0]                        rem;
  logic [BIT_W-1:0]                     bit_cnt;
  logic signed [SW-1:0]                 acc;

  logic                                 out_valid;
  logic [gcvbp_pkg::BLK_W-1:0]          out_blk;
  logic signed [SW-1:0]                 out_score;
  logic                                 out_found;

  logic [gcvbp_pkg::BLK_W-1:0]          blk_in;
  logic                                 new_blk, boundary;
  logic [EXT_W-1:0]                     entry_ext;
  logic [ID_BITS-1:0]                   id_raw;
  logic [31:0]                          id_val, del_code_val, free_code_val;
  logic                                 is_del, is_free;
  logic [CW-1:0]                        base_del, base_free, base_used;
  logic [CW-1:0]                        del_upd, free_upd, used_upd;
  logic [gcvbp_pkg::ERA_W-1:0]          era_upd;

  logic [PW-1:0]                        den;
  logic signed [WW-1:0]                 w_sel;
  logic [CW-1:0]                        c_sel;
  logic signed [PROD_W-1:0]             mul_res;
  logic [PROD_W-1:0]                    prod_abs;
  logic [DIV_W-1:0]                     dividend;
  logic [PW:0]                          trial;
  logic [PW-1:0]                        rem_next;
  logic                                 qbit;
  logic [gcvbp_pkg::ERA_W-1:0]          age_gap;
  logic signed [EAGE_W-1:0]             eage_prod;
  logic signed [SW-1:0]                 q_ext;
  logic                                 better;

  always_comb begin
    blk_in        = gcvbp_pkg::blk_mod(scan.block_index, NUM_BLOCKS);
    new_blk       = !seen || (blk_in != cur_blk);
    boundary      = seen && (blk_in != cur_blk);
    entry_ext     = EXT_W'(scan.lookup_entry);
    id_raw        = entry_ext[FLAG_BITS +: ID_BITS];
    id_val        = {{(32 - ID_BITS){id_raw[ID_BITS-1]}}, id_raw};
    del_code_val  = {{(32 - gcvbp_pkg::CODE_W){deleted_id_code[gcvbp_pkg::CODE_W-1]}},
                     deleted_id_code};
    free_code_val = {{(32 - gcvbp_pkg::CODE_W){free_id_code[gcvbp_pkg::CODE_W-1]}},
                     free_id_code};
    is_del        = (id_val == del_code_val);
    is_free       = !is_del && (id_val == free_code_val);
    base_del      = new_blk ? '0 : del_cnt;
    base_free     = new_blk ? '0 : free_cnt;
    base_used     = new_blk ? '0 : used_cnt;
    del_upd       = base_del + CW'(is_del && (base_del != gcvbp_pkg::COUNT_MAX));
    free_upd      = base_free + CW'(is_free && (base_free != gcvbp_pkg::COUNT_MAX));
    used_upd      = base_used + CW'(!is_del && !is_free &&
                                    (base_used != gcvbp_pkg::COUNT_MAX));
    era_upd       = new_blk ? scan.erase_count : cur_era;
  end

  always_comb begin
    den = (pages_per_block == '0) ? PW'(1) : pages_per_block;
    case (term)
      2'd0:    begin w_sel = weight_deleted; c_sel = s_del;  end
      2'd1:    begin w_sel = weight_free;    c_sel = s_free; end
      default: begin w_sel = weight_used;    c_sel = s_used; end
    endcase
    mul_res   = PROD_W'(w_sel * $signed({1'b0, c_sel}));
    prod_abs  = prod[PROD_W-1] ? PROD_W'(-prod) : PROD_W'(prod);
    dividend  = {prod_abs[MAG_W-1:0], {gcvbp_pkg::SCALE_SHIFT{1'b0}}} +
                DIV_W'(den >> 1);
    trial     = {rem, quo[DIV_W-1]};
    qbit      = (trial >= {1'b0, den});
    rem_next  = qbit ? PW'(trial - {1'b0, den}) : trial[PW-1:0];
    age_gap   = max_erase_count - s_era;
    eage_prod = EAGE_W'(weight_erase_age * $signed({1'b0, age_gap}));
    q_ext     = SW'(quo);
    better    = !best_valid || (acc > best_score) ||
                ((acc == best_score) && (s_del > best_del));
  end

  assign scan.ready             = (state == ST_IDLE);
  assign result.valid           = out_valid;
  assign result.candidate_block = out_blk;
  assign result.candidate_score = out_score;
  assign result.found           = out_found;

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      weight_erase_age <= '0;
      weight_deleted   <= '0;
      weight_free      <= '0;
      weight_used      <= '0;
      max_erase_count  <= '0;
      pages_per_block  <= gcvbp_pkg::PPB_RESET;
      deleted_id_code  <= '1;
      free_id_code     <= '0;
      seen             <= 1'b0;
      cur_blk          <= '0;
      cur_era          <= '0;
      del_cnt          <= '0;
      free_cnt         <= '0;
      used_cnt         <= '0;
      best_score       <= gcvbp_pkg::SCORE_FLOOR;
      best_del         <= '0;
      best_blk         <= '0;
      best_valid       <= 1'b0;
      pend_last        <= 1'b0;
      final_pass       <= 1'b0;
      out_valid        <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_index)
          gcvbp_pkg::REG_WEIGHT_ERASE_AGE: weight_erase_age <= cfg_data[WW-1:0];
          gcvbp_pkg::REG_WEIGHT_DELETED:   weight_deleted   <= cfg_data[WW-1:0];
          gcvbp_pkg::REG_WEIGHT_FREE:      weight_free      <= cfg_data[WW-1:0];
          gcvbp_pkg::REG_WEIGHT_USED:      weight_used      <= cfg_data[WW-1:0];
          gcvbp_pkg::REG_MAX_ERASE_COUNT:  max_erase_count  <= cfg_data;
          gcvbp_pkg::REG_PAGES_PER_BLOCK:  pages_per_block  <= cfg_data[PW-1:0];
          gcvbp_pkg::REG_DELETED_ID_CODE:  deleted_id_code  <= cfg_data;
          gcvbp_pkg::REG_FREE_ID_CODE:     free_id_code     <= cfg_data;
          default: ;
        endcase
      end

      if (result.valid && result.ready && (state != ST_EMIT)) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (scan.valid) begin
            seen      <= 1'b1;
            cur_blk   <= blk_in;
            cur_era   <= era_upd;
            del_cnt   <= del_upd;
            free_cnt  <= free_upd;
            used_cnt  <= used_upd;
            pend_last <= scan.last_entry;
            if (boundary) begin
              s_blk      <= cur_blk;
              s_era      <= cur_era;
              s_del      <= del_cnt;
              s_free     <= free_cnt;
              s_used     <= used_cnt;
              final_pass <= 1'b0;
              state      <= ST_EAGE;
            end else if (scan.last_entry) begin
              s_blk      <= blk_in;
              s_era      <= era_upd;
              s_del      <= del_upd;
              s_free     <= free_upd;
              s_used     <= used_upd;
              final_pass <= 1'b1;
              state      <= ST_EAGE;
            end
          end
        end
        ST_EAGE: begin
          acc   <= SW'(eage_prod);
          term  <= 2'd0;
          state <= ST_MUL;
        end
        ST_MUL: begin
          prod  <= mul_res;
          state <= ST_PREP;
        end
        ST_PREP: begin
          neg     <= prod[PROD_W-1];
          quo     <= dividend;
          rem     <= '0;
          bit_cnt <= '0;
          state   <= ST_DIV;
        end
        ST_DIV: begin
          rem     <= rem_next;
          quo     <= {quo[DIV_W-2:0], qbit};
          bit_cnt <= bit_cnt + BIT_W'(1);
          if (bit_cnt == BIT_W'(DIV_W - 1)) begin
            state <= ST_ACC;
          end
        end
        ST_ACC: begin
          acc <= neg ? (acc - q_ext) : (acc + q_ext);
          if (term == 2'd2) begin
            state <= ST_CMP;
          end else begin
            term  <= term + 2'd1;
            state <= ST_MUL;
          end
        end
        ST_CMP: begin
          if (better) begin
            best_score <= acc;
            best_del   <= s_del;
            best_blk   <= s_blk;
            best_valid <= 1'b1;
          end
          if (final_pass) begin
            state <= ST_EMIT;
          end else if (pend_last) begin
            state <= ST_SNAP;
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_SNAP: begin
          s_blk      <= cur_blk;
          s_era      <= cur_era;
          s_del      <= del_cnt;
          s_free     <= free_cnt;
          s_used     <= used_cnt;
          final_pass <= 1'b1;
          state      <= ST_EAGE;
        end
        ST_EMIT: begin
          if (!out_valid || result.ready) begin
            out_valid  <= 1'b1;
            out_blk    <= best_valid ? best_blk : '0;
            out_score  <= best_valid ? best_score : '0;
            out_found  <= best_valid;
            seen       <= 1'b0;
            cur_blk    <= '0;
            cur_era    <= '0;
            del_cnt    <= '0;
            free_cnt   <= '0;
            used_cnt   <= '0;
            best_score <= gcvbp_pkg::SCORE_FLOOR;
            best_del   <= '0;
            best_blk   <= '0;
            best_valid <= 1'b0;
            pend_last  <= 1'b0;
            final_pass <= 1'b0;
            state      <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
